>>> sv/wvt_pkg.sv
// Package for the wall view transform and near clip unit.
// Holds widths, register index codes and divider flag types.
// No dependencies.
`default_nettype none

package wvt_pkg;

   // default fraction bits of the Q format
   localparam int WVT_FRAC_BITS = 16;

   // width of the intersection numerators and denominators
   localparam int NUM_W = 104;
   localparam int DEN_W = 64;
   // width of the frustum constants
   localparam int CONST_W = 48;

   // quotient bits resolved by the divider, and its stage count
   localparam int QUO_W   = 32;
   localparam int DIV_LAT = QUO_W + 3;

   // configuration register indexes
   localparam logic [1:0] CSR_CAMERA_X = 2'd0;
   localparam logic [1:0] CSR_CAMERA_Y = 2'd1;
   localparam logic [1:0] CSR_VIEW_SIN = 2'd2;
   localparam logic [1:0] CSR_VIEW_COS = 2'd3;

   // sign and special case flags that travel with a division
   typedef struct packed {
      logic num_neg;
      logic den_neg;
      logic num_zero;
      logic den_zero;
      logic big;
   } div_flags_type;

endpackage

`default_nettype wire

>>> sv/wall_view_transform_near_clip_unit.sv
// Wall view transform and near clip: rotation, frustum intersection, clip select.
// Pipeline of 7 arithmetic stages, 35 divider stages and an output register.
// Throughput one transaction per cycle; the whole pipeline holds only while a
// result waits on the output.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// Depends on wvt_pkg and wvt_div_pipe.
`default_nettype none

module wall_view_transform_near_clip_unit
   import wvt_pkg::*;
#(
   parameter int FRAC_BITS = WVT_FRAC_BITS
)
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // first_x, first_y, second_x, second_y
   input  wire [127:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // view_x_first, view_depth_first, view_x_second, view_depth_second
   output logic [127:0] rsp_tdata,
   // clip_status, degenerate
   output logic [1:0]  rsp_tuser,
   input  wire         csr_we,
   input  wire [1:0]   csr_index,
   input  wire [31:0]  csr_wdata
);

   // frustum constants
   localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
   localparam longint NEAR_Z_RAW  = (ONE_Q + 5000) / 10000;
   localparam longint NEAR_S_RAW  = (ONE_Q + 50000) / 100000;
   localparam longint NEAR_Z      = (NEAR_Z_RAW > 0) ? NEAR_Z_RAW : 1;
   localparam longint NEAR_SIDE   = (NEAR_S_RAW > 0) ? NEAR_S_RAW : 1;
   localparam longint FAR_Z       = 5 * ONE_Q;
   localparam longint FAR_SIDE    = 20 * ONE_Q;
   localparam logic signed [CONST_W-1:0] DS_L = CONST_W'(FAR_SIDE - NEAR_SIDE);
   localparam logic signed [CONST_W-1:0] DS_R = CONST_W'(NEAR_SIDE - FAR_SIDE);
   localparam logic signed [CONST_W-1:0] DNZ  = CONST_W'(NEAR_Z - FAR_Z);
   localparam logic signed [CONST_W-1:0] B_L  =
      CONST_W'(NEAR_Z * FAR_SIDE - NEAR_SIDE * FAR_Z);
   localparam logic signed [CONST_W-1:0] B_R  =
      CONST_W'(NEAR_SIDE * FAR_Z - NEAR_Z * FAR_SIDE);
   localparam logic signed [31:0] NZ32 = 32'(NEAR_Z);
   localparam int PIPE_D = 7 + DIV_LAT + 1;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] z1;
      logic signed [31:0] x2;
      logic signed [31:0] z2;
      logic               clip;
      logic               degen;
   } side_type;

   // configuration registers
   logic signed [31:0] cam_x_ff, cam_y_ff;
   logic signed [15:0] sin_ff, cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         sin_ff   <= '0;
         cos_ff   <= 16'sd16384;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAMERA_X: cam_x_ff <= csr_wdata;
            CSR_CAMERA_Y: cam_y_ff <= csr_wdata;
            CSR_VIEW_SIN: sin_ff   <= csr_wdata[15:0];
            CSR_VIEW_COS: cos_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // pipeline control: global hold while the output waits
   logic              advance;
   logic [PIPE_D-1:0] valid_ff;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[PIPE_D-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[PIPE_D-2:0], req_tvalid};
   end

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh0_7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
      else if (v < -36'sh0_8000_0000) sat32 = 32'sh8000_0000;
      else                            sat32 = v[31:0];
   endfunction

   // S1: differences from the camera
   logic signed [32:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         d1x_ff <= $signed({req_tdata[31], req_tdata[31:0]})    - 33'(cam_x_ff);
         d1y_ff <= $signed({req_tdata[63], req_tdata[63:32]})   - 33'(cam_y_ff);
         d2x_ff <= $signed({req_tdata[95], req_tdata[95:64]})   - 33'(cam_x_ff);
         d2y_ff <= $signed({req_tdata[127], req_tdata[127:96]}) - 33'(cam_y_ff);
      end
   end

   // S2: rotation products
   logic signed [48:0] p1xs_ff, p1yc_ff, p1xc_ff, p1ys_ff;
   logic signed [48:0] p2xs_ff, p2yc_ff, p2xc_ff, p2ys_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p1xs_ff <= d1x_ff * sin_ff;
         p1yc_ff <= d1y_ff * cos_ff;
         p1xc_ff <= d1x_ff * cos_ff;
         p1ys_ff <= d1y_ff * sin_ff;
         p2xs_ff <= d2x_ff * sin_ff;
         p2yc_ff <= d2y_ff * cos_ff;
         p2xc_ff <= d2x_ff * cos_ff;
         p2ys_ff <= d2y_ff * sin_ff;
      end
   end

   // S3: sums, floor by 2^14, saturate
   logic signed [49:0] r1x_in, r1z_in, r2x_in, r2z_in;
   logic signed [31:0] x1_ff, z1_ff, x2_ff, z2_ff;
   always_comb begin
      r1x_in = 50'(p1xs_ff) - 50'(p1yc_ff);
      r1z_in = 50'(p1xc_ff) + 50'(p1ys_ff);
      r2x_in = 50'(p2xs_ff) - 50'(p2yc_ff);
      r2z_in = 50'(p2xc_ff) + 50'(p2ys_ff);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff <= sat32($signed(r1x_in[49:14]));
         z1_ff <= sat32($signed(r1z_in[49:14]));
         x2_ff <= sat32($signed(r2x_in[49:14]));
         z2_ff <= sat32($signed(r2z_in[49:14]));
      end
   end

   // S4: cross products and segment deltas
   side_type           s4_ff;
   logic signed [63:0] pa_ff, pb_ff;
   logic signed [32:0] dx4_ff, dz4_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff.x1    <= x1_ff;
         s4_ff.z1    <= z1_ff;
         s4_ff.x2    <= x2_ff;
         s4_ff.z2    <= z2_ff;
         s4_ff.clip  <= !(z1_ff > 0 && z2_ff > 0);
         s4_ff.degen <= 1'b0;
         pa_ff       <= x1_ff * z2_ff;
         pb_ff       <= z1_ff * x2_ff;
         dx4_ff      <= 33'(x1_ff) - 33'(x2_ff);
         dz4_ff      <= 33'(z1_ff) - 33'(z2_ff);
      end
   end

   // S5: a term, denominator products, b products
   side_type             s5_ff;
   logic signed [64:0]   a5_ff;
   logic signed [DEN_W-1:0] dxdnz_ff, dzdsl_ff, dzdsr_ff;
   logic signed [NUM_W-1:0] bldx5_ff, bldz5_ff, brdx5_ff, brdz5_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s5_ff    <= s4_ff;
         a5_ff    <= 65'(pa_ff) - 65'(pb_ff);
         dxdnz_ff <= DEN_W'(dx4_ff * DNZ);
         dzdsl_ff <= DEN_W'(dz4_ff * DS_L);
         dzdsr_ff <= DEN_W'(dz4_ff * DS_R);
         bldx5_ff <= NUM_W'(dx4_ff * B_L);
         bldz5_ff <= NUM_W'(dz4_ff * B_L);
         brdx5_ff <= NUM_W'(dx4_ff * B_R);
         brdz5_ff <= NUM_W'(dz4_ff * B_R);
      end
   end

   // S6: denominators, partial products of a split into high and low halves
   logic signed [33:0]   alo_in;
   logic signed [31:0]   ahi_in;
   side_type             s6_ff;
   logic signed [DEN_W-1:0] denl_ff, denr_ff;
   logic signed [NUM_W-1:0] lsl_ff, hsl_ff, lsr_ff, hsr_ff, lnz_ff, hnz_ff;
   logic signed [NUM_W-1:0] bldx6_ff, bldz6_ff, brdx6_ff, brdz6_ff;
   assign alo_in = $signed({1'b0, a5_ff[32:0]});
   assign ahi_in = a5_ff[64:33];
   always_ff @(posedge clock) begin
      if (advance) begin
         s6_ff    <= s5_ff;
         denl_ff  <= dxdnz_ff - dzdsl_ff;
         denr_ff  <= dxdnz_ff - dzdsr_ff;
         lsl_ff   <= NUM_W'(alo_in * DS_L);
         hsl_ff   <= NUM_W'(ahi_in * DS_L);
         lsr_ff   <= NUM_W'(alo_in * DS_R);
         hsr_ff   <= NUM_W'(ahi_in * DS_R);
         lnz_ff   <= NUM_W'(alo_in * DNZ);
         hnz_ff   <= NUM_W'(ahi_in * DNZ);
         bldx6_ff <= bldx5_ff;
         bldz6_ff <= bldz5_ff;
         brdx6_ff <= brdx5_ff;
         brdz6_ff <= brdz5_ff;
      end
   end

   // S7: numerators, zero denominator flag
   side_type             s7_in;
   side_type             s7_ff;
   logic signed [NUM_W-1:0] xl_ff, zl_ff, xr_ff, zr_ff;
   logic signed [DEN_W-1:0] denl7_ff, denr7_ff;
   always_comb begin
      s7_in       = s6_ff;
      s7_in.degen = (denl_ff == '0) || (denr_ff == '0);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s7_ff       <= s7_in;
         xl_ff       <= (hsl_ff <<< 33) + lsl_ff - bldx6_ff;
         zl_ff       <= (hnz_ff <<< 33) + lnz_ff - bldz6_ff;
         xr_ff       <= (hsr_ff <<< 33) + lsr_ff - brdx6_ff;
         zr_ff       <= (hnz_ff <<< 33) + lnz_ff - brdz6_ff;
         denl7_ff    <= denl_ff;
         denr7_ff    <= denr_ff;
      end
   end

   // dividers for both frustum lines
   logic signed [31:0] lx_q, lz_q, rx_q, rz_q;

   wvt_div_pipe u_div_lx (.clock, .advance, .num_in(xl_ff), .den_in(denl7_ff),
                          .quo_out(lx_q));
   wvt_div_pipe u_div_lz (.clock, .advance, .num_in(zl_ff), .den_in(denl7_ff),
                          .quo_out(lz_q));
   wvt_div_pipe u_div_rx (.clock, .advance, .num_in(xr_ff), .den_in(denr7_ff),
                          .quo_out(rx_q));
   wvt_div_pipe u_div_rz (.clock, .advance, .num_in(zr_ff), .den_in(denr7_ff),
                          .quo_out(rz_q));

   // side data delay line matching the dividers
   side_type side_ff [0:DIV_LAT-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= s7_ff;
         for (int k = 1; k < DIV_LAT; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // output stage: endpoint replacement
   side_type           sd;
   logic signed [31:0] px_in, pz_in;
   logic signed [31:0] ox1_in, oz1_in, ox2_in, oz2_in;
   always_comb begin
      sd     = side_ff[DIV_LAT-1];
      px_in  = (lz_q > 0) ? lx_q : rx_q;
      pz_in  = (lz_q > 0) ? lz_q : rz_q;
      ox1_in = sd.x1;
      oz1_in = sd.z1;
      ox2_in = sd.x2;
      oz2_in = sd.z2;
      if (sd.clip && sd.z1 < NZ32) begin
         ox1_in = px_in;
         oz1_in = pz_in;
      end
      if (sd.clip && sd.z2 < NZ32) begin
         ox2_in = px_in;
         oz2_in = pz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata <= {oz2_in, ox2_in, oz1_in, ox1_in};
         rsp_tuser <= {sd.clip && sd.degen, sd.clip};
      end
   end

   // checks
   a_degen_only_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("degenerate flagged on unclipped transaction");

   a_unclipped_in_front: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         $signed(rsp_tdata[63:32]) > 0 && $signed(rsp_tdata[127:96]) > 0)
      else $error("unclipped transaction with depth not positive");

   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> sv/wvt_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, saturating to 32 bits.
// Depends on wvt_pkg for widths and the flag type.
`default_nettype none

module wvt_div_pipe
   import wvt_pkg::*;
(
   input  wire                       clock,
   input  wire                       advance,
   input  wire logic signed [NUM_W-1:0] num_in,
   input  wire logic signed [DEN_W-1:0] den_in,
   output logic signed [31:0]        quo_out
);

   // stage A: magnitudes and signs
   logic [NUM_W-1:0]  nmag_ff;
   logic [DEN_W-1:0]  dmag_ff;
   div_flags_type     fla_ff;

   // stage B and the bit steps
   logic [NUM_W-1:0]  rem_ff [0:QUO_W];
   logic [DEN_W-1:0]  dv_ff  [0:QUO_W];
   logic [QUO_W-1:0]  q_ff   [0:QUO_W];
   div_flags_type     fl_ff  [0:QUO_W];

   logic [NUM_W-1:0]  lim_in;
   div_flags_type     flb_in;
   logic signed [31:0] quo_in;

   // limit for a quotient that does not fit in 32 bits
   assign lim_in = NUM_W'(dmag_ff) << QUO_W;

   always_comb begin
      flb_in     = fla_ff;
      flb_in.big = (nmag_ff >= lim_in);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nmag_ff          <= num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);
         dmag_ff          <= den_in[DEN_W-1] ? DEN_W'(-den_in) : DEN_W'(den_in);
         fla_ff.num_neg   <= num_in[NUM_W-1];
         fla_ff.den_neg   <= den_in[DEN_W-1];
         fla_ff.num_zero  <= (num_in == '0);
         fla_ff.den_zero  <= (den_in == '0);
         fla_ff.big       <= 1'b0;
      end
   end

   // stage B load, then one quotient bit per stage, most significant first
   always_ff @(posedge clock) begin
      logic [NUM_W-1:0] trial;
      if (advance) begin
         rem_ff[0] <= nmag_ff;
         dv_ff[0]  <= dmag_ff;
         q_ff[0]   <= '0;
         fl_ff[0]  <= flb_in;
         for (int k = 0; k < QUO_W; k++) begin
            trial = NUM_W'(dv_ff[k]) << (QUO_W - 1 - k);
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               q_ff[k+1]   <= q_ff[k] | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               q_ff[k+1]   <= q_ff[k];
            end
            dv_ff[k+1] <= dv_ff[k];
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   // sign, saturation and zero denominator
   always_comb begin
      if (fl_ff[QUO_W].den_zero) begin
         if (fl_ff[QUO_W].num_zero)     quo_in = 32'sd0;
         else if (fl_ff[QUO_W].num_neg) quo_in = 32'sh8000_0000;
         else                            quo_in = 32'sh7FFF_FFFF;
      end else if (fl_ff[QUO_W].num_neg != fl_ff[QUO_W].den_neg) begin
         if (fl_ff[QUO_W].big || q_ff[QUO_W][QUO_W-1]) quo_in = 32'sh8000_0000;
         else quo_in = -$signed(q_ff[QUO_W]);
      end else begin
         if (fl_ff[QUO_W].big || q_ff[QUO_W][QUO_W-1]) quo_in = 32'sh7FFF_FFFF;
         else quo_in = $signed(q_ff[QUO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) quo_out <= quo_in;
   end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for wall_view_transform_near_clip_unit: directed table, then random walls.
// Self-checking against an in-bench fixed point predictor; depends on wvt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top
   import wvt_pkg::*;
;

   localparam int NEAR_Z    = 7;        // round(1e-4 * 2^16)
   localparam int NEAR_SIDE = 1;        // round(1e-5 * 2^16)
   localparam longint FAR_Z    = 64'sd5 << 16;
   localparam longint FAR_SIDE = 64'sd20 << 16;
   localparam longint S32_MAX  = 64'sd2147483647;
   localparam longint S32_MIN  = -64'sd2147483648;
   localparam int LIMIT = 400000;
   localparam int N_RANDOM = 1430;

   typedef struct {
      logic [31:0] x1, z1, x2, z2;
      logic        clipped, degen;
   } wall_view_type;

   typedef struct {
      logic [31:0] ax, ay, bx, by;
      logic        has_exp;     // typed-in expectation present
      wall_view_type want;
   } wall_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [127:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [1:0]  csr_index = CSR_CAMERA_X;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the registers
   logic signed [31:0] cam_x, cam_y;
   logic signed [15:0] v_sin, v_cos;

   wall_view_type pending_views[$];
   int errors = 0;
   int cycles = 0;
   int n_sent = 0, n_checked = 0, n_clipped = 0, n_degen = 0;
   bit stall_hold = 0;
   bit quiet = 0;

   wall_view_transform_near_clip_unit u_top (.*);

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic longint sat32(longint v);
      return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
   endfunction

   // truncating divide with saturation; zero divisor flags degenerate
   function automatic longint div_sat(logic signed [127:0] num, longint den, ref bit degen);
      logic signed [127:0] q;
      if (den == 0) begin
         degen = 1;
         if (num == 0) return 0;
         return num < 0 ? S32_MIN : S32_MAX;
      end
      q = num / 128'(signed'(den));
      if (q > S32_MAX) return S32_MAX;
      if (q < S32_MIN) return S32_MIN;
      return longint'(q);
   endfunction

   function automatic void frustum_hit(longint x1, longint z1, longint x2, longint z2,
                                       longint sn, longint sf,
                                       ref longint ox, ref longint oz, ref bit degen);
      longint dx, dz, ds, dnz, b, den;
      logic signed [127:0] a, xn, zn;
      dx = x1 - x2; dz = z1 - z2;
      ds = sn - sf; dnz = NEAR_Z - FAR_Z;
      b = sn * FAR_Z - NEAR_Z * sf;
      den = dx * dnz - dz * ds;
      a = 128'(signed'(x1 * z2)) - 128'(signed'(z1 * x2));
      xn = a * 128'(signed'(ds)) - 128'(signed'(b)) * 128'(signed'(dx));
      zn = a * 128'(signed'(dnz)) - 128'(signed'(b)) * 128'(signed'(dz));
      ox = div_sat(xn, den, degen);
      oz = div_sat(zn, den, degen);
   endfunction

   // view transform plus near clip of one wall
   function automatic wall_view_type project_wall(logic [31:0] ax, ay, bx, by);
      wall_view_type r;
      longint s, c, d1x, d1y, d2x, d2y, x1, z1, x2, z2, lx, lz, rx, rz, px, pz;
      bit degen;
      s = v_sin; c = v_cos;
      d1x = longint'(signed'(ax)) - cam_x; d1y = longint'(signed'(ay)) - cam_y;
      d2x = longint'(signed'(bx)) - cam_x; d2y = longint'(signed'(by)) - cam_y;
      x1 = sat32((d1x * s - d1y * c) >>> 14);
      z1 = sat32((d1x * c + d1y * s) >>> 14);
      x2 = sat32((d2x * s - d2y * c) >>> 14);
      z2 = sat32((d2x * c + d2y * s) >>> 14);
      degen = 0;
      r.clipped = 0;
      if (!(z1 > 0 && z2 > 0)) begin
         frustum_hit(x1, z1, x2, z2, -NEAR_SIDE, -FAR_SIDE, lx, lz, degen);
         frustum_hit(x1, z1, x2, z2, NEAR_SIDE, FAR_SIDE, rx, rz, degen);
         px = lz > 0 ? lx : rx;
         pz = lz > 0 ? lz : rz;
         if (z1 < NEAR_Z) begin x1 = px; z1 = pz; end
         if (z2 < NEAR_Z) begin x2 = px; z2 = pz; end
         r.clipped = 1;
      end
      r.x1 = x1[31:0]; r.z1 = z1[31:0]; r.x2 = x2[31:0]; r.z2 = z2[31:0];
      r.degen = degen;
      return r;
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_CAMERA_X: cam_x = val;
         CSR_CAMERA_Y: cam_y = val;
         CSR_VIEW_SIN: v_sin = val[15:0];
         CSR_VIEW_COS: v_cos = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_view(logic [31:0] cx, cy, logic [15:0] s, c);
      write_csr(CSR_CAMERA_X, cx);
      write_csr(CSR_CAMERA_Y, cy);
      write_csr(CSR_VIEW_SIN, {{16{s[15]}}, s});
      write_csr(CSR_VIEW_COS, {{16{c[15]}}, c});
   endtask

   // offer one wall, with optional idle burst before it
   task automatic send_wall(wall_row_type w);
      wall_view_type p;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      p = w.has_exp ? w.want : project_wall(w.ax, w.ay, w.bx, w.by);
      req_tvalid <= 1;
      req_tdata <= {w.by, w.bx, w.ay, w.ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_views.push_back(p);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_views.size() != 0 && cycles < LIMIT) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
         default: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   // receiver: random stalls, one long hold-off on request
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall_hold) begin
            rsp_tready <= 0;
            repeat (300) @(negedge clock);
            stall_hold = 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // result checker
   always @(posedge clock) begin
      wall_view_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_views.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = pending_views.pop_front();
            n_checked++;
            if (rsp_tuser[0]) n_clipped++;
            if (rsp_tuser[1]) n_degen++;
            if (rsp_tdata[31:0] !== e.x1) begin
               $error("view_x_first exp %h got %h", e.x1, rsp_tdata[31:0]); errors++;
            end
            if (rsp_tdata[63:32] !== e.z1) begin
               $error("view_depth_first exp %h got %h", e.z1, rsp_tdata[63:32]); errors++;
            end
            if (rsp_tdata[95:64] !== e.x2) begin
               $error("view_x_second exp %h got %h", e.x2, rsp_tdata[95:64]); errors++;
            end
            if (rsp_tdata[127:96] !== e.z2) begin
               $error("view_depth_second exp %h got %h", e.z2, rsp_tdata[127:96]); errors++;
            end
            if (rsp_tuser[0] !== e.clipped) begin
               $error("clip_status exp %b got %b", e.clipped, rsp_tuser[0]); errors++;
            end
            if (rsp_tuser[1] !== e.degen) begin
               $error("degenerate exp %b got %b", e.degen, rsp_tuser[1]); errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      wall_row_type dir_walls[$];
      wall_row_type w;
      int k;
      cam_x = 0; cam_y = 0; v_sin = 0; v_cos = 16384;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // after reset: identity-like view, x' = -y, z = x
      w = '{ax: 32'h0001_0000, ay: 0, bx: 32'h0002_0000, by: 32'h0001_0000,
            has_exp: 1, want: '{32'h0, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 0, 0}};
      dir_walls.push_back(w);
      // both endpoints at the camera: zero denominators
      w = '{ax: 0, ay: 0, bx: 0, by: 0, has_exp: 1, want: '{0, 0, 0, 0, 1, 1}};
      dir_walls.push_back(w);
      // field extremes, both ends behind, crossing the near plane, on the near limit
      w = '{default: 0}; w.ax = 32'h7fffffff; w.ay = 32'h80000000;
      w.bx = 32'h80000000; w.by = 32'h7fffffff; dir_walls.push_back(w);
      w = '{default: 0}; w.ax = 32'hfff0_0000; w.ay = 32'h0001_0000;
      w.bx = 32'hffe0_0000; w.by = 32'hfffe_0000; dir_walls.push_back(w);
      w = '{default: 0}; w.ax = 32'h0010_0000; w.ay = 32'h0001_0000;
      w.bx = 32'hfff0_0000; w.by = 32'hfffc_0000; dir_walls.push_back(w);
      w = '{default: 0}; w.ax = NEAR_Z; w.ay = 0; w.bx = NEAR_Z - 1; w.by = 32'h0003_0000;
      dir_walls.push_back(w);
      w = '{default: 0}; w.ax = 32'hffffffff; w.ay = 32'hffffffff;
      w.bx = 32'hffffffff; w.by = 32'hffffffff; dir_walls.push_back(w);
      w = '{default: 0}; w.ax = 0; w.ay = 32'h0005_0000; w.bx = 0; w.by = 32'hfffb_0000;
      dir_walls.push_back(w);
      foreach (dir_walls[i]) send_wall(dir_walls[i]);
      drain();

      // register extremes and out of range sine/cosine
      set_view(32'h7fffffff, 32'h80000000, 16'h4000, 16'hc000);
      for (k = 0; k < 6; k++) begin
         w = '{default: 0};
         w.ax = rand_coord(); w.ay = rand_coord(); w.bx = rand_coord(); w.by = rand_coord();
         send_wall(w);
      end
      drain();
      set_view(32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000);
      for (k = 0; k < 6; k++) begin
         w = '{default: 0};
         w.ax = rand_coord(); w.ay = rand_coord(); w.bx = rand_coord(); w.by = rand_coord();
         send_wall(w);
      end
      drain();

      // random phases, each with its own camera
      for (k = 0; k < N_RANDOM; k++) begin
         if (k % 200 == 0) begin
            drain();
            set_view($urandom_range(0, 1) ? $urandom
                                          : 32'(signed'($urandom_range(0, 1 << 21)) - (1 << 20)),
                     $urandom_range(0, 1) ? $urandom
                                          : 32'(signed'($urandom_range(0, 1 << 21)) - (1 << 20)),
                     16'(signed'($urandom_range(0, 32768)) - 16384),
                     16'(signed'($urandom_range(0, 32768)) - 16384));
         end
         if (k == 400) stall_hold = 1;
         if (k == N_RANDOM - 150) quiet = 1;
         w = '{default: 0};
         w.ax = rand_coord(); w.ay = rand_coord(); w.bx = rand_coord(); w.by = rand_coord();
         send_wall(w);
      end
      drain();

      $display("tb_top: %0d walls sent, %0d results checked (%0d clipped, %0d degenerate)",
               n_sent, n_checked, n_clipped, n_degen);
      if (errors == 0 && pending_views.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
